// ===== hw/rtl/mhr_pkg.sv =====
// ----------------------------------------------------------------------------
// mhr_pkg: shared types and constants of the min-heap replace-top unit
// Field widths, request codes, status codes and the default heap capacity.
// ----------------------------------------------------------------------------
package mhr_pkg;

  localparam int unsigned KEY_W            = 64;
  localparam int unsigned SRC_W            = 4;
  localparam int unsigned REQ_W            = 3;
  localparam int unsigned CNT_OUT_W        = 5;
  localparam int unsigned STAT_W           = 2;
  localparam int unsigned ENTRY_W          = KEY_W + SRC_W;
  localparam int unsigned DEFAULT_CAPACITY = 16;

  // Request codes; codes 5 to 7 behave as a read of the top.
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND  = 3'd0,
    REQ_HEAPIFY = 3'd1,
    REQ_REPLACE = 3'd2,
    REQ_CLEAR   = 3'd3,
    REQ_READ    = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

endpackage

// ===== hw/rtl/mhr_if.sv =====
// ----------------------------------------------------------------------------
// mhr_in_if / mhr_out_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mhr_in_if;
  import mhr_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key;
  logic [SRC_W-1:0] source_id;

  modport source (output valid, output req_type, output key, output source_id,
                  input ready);
  modport sink   (input valid, input req_type, input key, input source_id,
                  output ready);
endinterface

interface mhr_out_if;
  import mhr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KEY_W-1:0]     top_key;
  logic [SRC_W-1:0]     top_source;
  logic [CNT_OUT_W-1:0] entry_count;
  logic [STAT_W-1:0]    status;

  modport source (output valid, output top_key, output top_source,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input top_key, input top_source,
                  input entry_count, input status, output ready);
endinterface

// ===== hw/rtl/mhr_ram.sv =====
// ----------------------------------------------------------------------------
// mhr_ram: generic RAM, one write port and two registered read ports
// Read data updates only when its port is enabled and holds otherwise.
// ----------------------------------------------------------------------------
module mhr_ram #(
  parameter int unsigned WIDTH = mhr_pkg::ENTRY_W,
  parameter int unsigned DEPTH = mhr_pkg::DEFAULT_CAPACITY
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_a_en,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic [WIDTH-1:0]         rd_a_data,
  input  logic                     rd_b_en,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

// ===== hw/rtl/min_heap_replace_top_unit.sv =====
// ----------------------------------------------------------------------------
// min_heap_replace_top_unit: binary min-heap with replace-top sift-down
// Append, clear and read go from the request transfer straight to the result state.
// Replace sifts down from the root, reading, comparing the left and then the right
// child at each level, until no child is smaller or a leaf is reached; heapify loads each start node and sifts it down.
// The unit takes one request at a time; the heap RAM and one 64-bit comparator
// are walked level by level. Reset empties the heap (count zero).
// ----------------------------------------------------------------------------
module min_heap_replace_top_unit #(
  parameter int unsigned CAPACITY = mhr_pkg::DEFAULT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  mhr_in_if.sink    in_chan,
  mhr_out_if.source out_chan
);
  import mhr_pkg::*;

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1); // holds 0..CAPACITY
  localparam int unsigned IDX_W  = $clog2(CAPACITY);     // RAM slot index
  localparam int unsigned CPOS_W = CNT_W + 1;            // child positions

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,  // wait for a request transfer
    S_LOAD = 6'b000010,  // heapify: capture the entry at start node i
    S_READ = 6'b000100,  // issue child reads, or settle at a leaf
    S_CMPL = 6'b001000,  // compare left child against the carried entry
    S_CMPR = 6'b010000,  // compare right child against the best so far
    S_DONE = 6'b100000   // hand the result to the output register
  } state_t;

  state_t              state_r, state_nxt;
  req_t                op_r, op_nxt;
  status_t             status_r, status_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;      // heapify start node
  logic [CNT_W-1:0]    pos_r, pos_nxt;  // hole being sifted, one-indexed
  logic [KEY_W-1:0]    cur_key_r, cur_key_nxt;
  logic [SRC_W-1:0]    cur_src_r, cur_src_nxt;
  logic [KEY_W-1:0]    best_key_r, best_key_nxt;
  logic [SRC_W-1:0]    best_src_r, best_src_nxt;
  logic [CNT_W-1:0]    best_pos_r, best_pos_nxt;
  logic [KEY_W-1:0]    top_key_r;
  logic [SRC_W-1:0]    top_src_r;

  logic                 out_valid_r;
  logic [KEY_W-1:0]     out_key_r;
  logic [SRC_W-1:0]     out_src_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic [STAT_W-1:0]    out_stat_r;

  // RAM ports
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [KEY_W-1:0]   wr_key;
  logic [SRC_W-1:0]   wr_src;
  logic               rd_a_en, rd_b_en;
  logic [IDX_W-1:0]   rd_a_addr, rd_b_addr;
  logic [ENTRY_W-1:0] rd_a_data, rd_b_data;
  logic [KEY_W-1:0]   rd_a_key, rd_b_key;
  logic [SRC_W-1:0]   rd_a_src, rd_b_src;

  // Shared comparator
  logic [KEY_W-1:0]   cmp_a, cmp_b;
  logic               cmp_lt;

  logic               accept;
  logic               out_take;
  logic               sift_end;
  logic [CPOS_W-1:0]  left_pos, right_pos, count_ext;
  logic [CNT_W-1:0]   half_cnt;
  logic [CNT_W-1:0]   fin_pos;
  logic [KEY_W-1:0]   fin_key;
  logic [SRC_W-1:0]   fin_src;
  logic               take_right;

  mhr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   ({wr_key, wr_src}),
    .rd_a_en   (rd_a_en),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_en   (rd_b_en),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  assign {rd_a_key, rd_a_src} = rd_a_data;
  assign {rd_b_key, rd_b_src} = rd_b_data;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_take      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  // Children of the hole; slots are position minus one.
  assign left_pos  = {pos_r, 1'b0};
  assign right_pos = {pos_r, 1'b1};
  assign count_ext = {1'b0, count_r};
  assign half_cnt  = count_r >> 1;

  // One comparator serves both child compares.
  always_comb begin
    if (state_r == S_CMPR) begin
      cmp_a = rd_b_key;
      cmp_b = best_key_r;
    end else begin
      cmp_a = rd_a_key;
      cmp_b = cur_key_r;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  // Winner of a level: strict less-than, so ties keep the parent / left child.
  assign take_right = (right_pos <= count_ext) && cmp_lt;
  assign fin_pos    = take_right ? CNT_W'(right_pos) : best_pos_r;
  assign fin_key    = take_right ? rd_b_key : best_key_r;
  assign fin_src    = take_right ? rd_b_src : best_src_r;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    status_nxt   = status_r;
    count_nxt    = count_r;
    i_nxt        = i_r;
    pos_nxt      = pos_r;
    cur_key_nxt  = cur_key_r;
    cur_src_nxt  = cur_src_r;
    best_key_nxt = best_key_r;
    best_src_nxt = best_src_r;
    best_pos_nxt = best_pos_r;
    wr_en        = 1'b0;
    wr_addr      = IDX_W'(pos_r - CNT_W'(1));
    wr_key       = cur_key_r;
    wr_src       = cur_src_r;
    rd_a_en      = 1'b0;
    rd_a_addr    = IDX_W'(left_pos - CPOS_W'(1));
    rd_b_en      = 1'b0;
    rd_b_addr    = IDX_W'(left_pos);
    sift_end     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = req_t'(in_chan.req_type);
          status_nxt = STAT_OK;
          state_nxt  = S_DONE;
          unique case (req_t'(in_chan.req_type))
            REQ_APPEND: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = IDX_W'(count_r);
                wr_key    = in_chan.key;
                wr_src    = in_chan.source_id;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_HEAPIFY: begin
              if (half_cnt != '0) begin
                i_nxt     = half_cnt;
                rd_a_en   = 1'b1;
                rd_a_addr = IDX_W'(half_cnt - CNT_W'(1));
                state_nxt = S_LOAD;
              end
            end
            REQ_REPLACE: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                cur_key_nxt = in_chan.key;
                cur_src_nxt = top_src_r;
                pos_nxt     = CNT_W'(1);
                state_nxt   = S_READ;
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end
            end
          endcase
        end
      end
      S_LOAD: begin
        cur_key_nxt = rd_a_key;
        cur_src_nxt = rd_a_src;
        pos_nxt     = i_r;
        state_nxt   = S_READ;
      end
      S_READ: begin
        if (left_pos > count_ext) begin
          // Leaf: drop the carried entry into the hole.
          wr_en    = 1'b1;
          sift_end = 1'b1;
        end else begin
          rd_a_en   = 1'b1;
          rd_b_en   = (right_pos <= count_ext);
          state_nxt = S_CMPL;
        end
      end
      S_CMPL: begin
        if (cmp_lt) begin
          best_key_nxt = rd_a_key;
          best_src_nxt = rd_a_src;
          best_pos_nxt = CNT_W'(left_pos);
        end else begin
          best_key_nxt = cur_key_r;
          best_src_nxt = cur_src_r;
          best_pos_nxt = pos_r;
        end
        state_nxt = S_CMPR;
      end
      S_CMPR: begin
        wr_en = 1'b1;
        if (fin_pos == pos_r) begin
          sift_end = 1'b1;
        end else begin
          // Move the smaller child up and descend into its slot.
          wr_key    = fin_key;
          wr_src    = fin_src;
          pos_nxt   = fin_pos;
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (out_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // End of one sift: advance heapify to the next start node, or finish.
    if (sift_end) begin
      if (op_r == REQ_HEAPIFY && i_r > CNT_W'(1)) begin
        i_nxt     = i_r - CNT_W'(1);
        rd_a_en   = 1'b1;
        rd_a_addr = IDX_W'(i_r - CNT_W'(2));
        state_nxt = S_LOAD;
      end else begin
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_take) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    status_r   <= status_nxt;
    i_r        <= i_nxt;
    pos_r      <= pos_nxt;
    cur_key_r  <= cur_key_nxt;
    cur_src_r  <= cur_src_nxt;
    best_key_r <= best_key_nxt;
    best_src_r <= best_src_nxt;
    best_pos_r <= best_pos_nxt;
    // Shadow the root so the result needs no extra RAM read.
    if (wr_en && wr_addr == '0) begin
      top_key_r <= wr_key;
      top_src_r <= wr_src;
    end
    if (out_take) begin
      out_key_r  <= (count_r == '0) ? '0 : top_key_r;
      out_src_r  <= (count_r == '0) ? '0 : top_src_r;
      out_cnt_r  <= CNT_OUT_W'(count_r);
      out_stat_r <= status_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.top_key     = out_key_r;
  assign out_chan.top_source  = out_src_r;
  assign out_chan.entry_count = out_cnt_r;
  assign out_chan.status      = out_stat_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("heap count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r == STAT_FULL |-> out_cnt_r == CNT_OUT_W'(CAPACITY))
    else $error("full status on a heap that is not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r == STAT_EMPTY |-> out_cnt_r == '0 && out_key_r == '0)
    else $error("empty status with entries or a nonzero top");

  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> i_r != '0 && i_r <= half_cnt)
    else $error("heapify start node out of range");

  a_child_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMPL |-> pos_r != '0 && left_pos <= count_ext)
    else $error("child compare beyond the heap");

endmodule
